/* sv/can_firmware_push_sequencer_top_macros.svh */
// Assertion helpers used by the sequencer core.
`ifndef CAN_FIRMWARE_PUSH_SEQUENCER_TOP_MACROS_SVH
`define CAN_FIRMWARE_PUSH_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CFPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sequencer check failed");

// Next-cycle implication, checked outside reset.
`define CFPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sequencer check failed");

`endif

/* sv/cfps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cfps_pkg;

	// Largest number of image bytes in one data frame.
	localparam int unsigned MAX_CHUNK = 5;
	localparam int unsigned CHUNK_NW = $clog2(MAX_CHUNK + 1);
	localparam int unsigned CHUNK_W = 40;
	localparam int unsigned PAYLOAD_W = 56;
	localparam int unsigned SEQ_W = 16;

	// Register file layout.
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_READY_TIMEOUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_REQUEST = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_READY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_ACK = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_DATA = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_END = 3'd6;
	localparam logic [15:0] READY_TIMEOUT_RST = 16'd60000;

	// Request kinds.
	typedef logic [1:0] req_kind_t;
	localparam req_kind_t REQ_POLL = 2'd0;
	localparam req_kind_t REQ_FRAME = 2'd1;
	localparam req_kind_t REQ_TICK = 2'd2;

	// Sequencer phases; the last code is the bad phase.
	typedef logic [1:0] phase_t;
	localparam phase_t PH_REQ = 2'd0;
	localparam phase_t PH_READY = 2'd1;
	localparam phase_t PH_SEND = 2'd2;
	localparam phase_t PH_BAD = 2'd3;

	// Frame lengths including the command byte.
	localparam logic [3:0] LEN_ACK = 4'd5;
	localparam logic [3:0] LEN_END = 4'd1;
	localparam logic [3:0] LEN_DATA_BASE = 4'd3;

	typedef struct packed {
		logic [31:0] image_size;
		logic [15:0] ready_timeout_ms;
		logic [7:0]  code_request;
		logic [7:0]  code_ready;
		logic [7:0]  code_ack;
		logic [7:0]  code_data;
		logic [7:0]  code_end;
	} cfg_regs_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic [3:0]         rx_length;
		logic [7:0]         rx_first_byte;
		logic [CHUNK_W-1:0] chunk_bytes;
	} req_item_t;

	typedef struct packed {
		logic                 frame_valid;
		logic [7:0]           frame_code;
		logic [3:0]           frame_length;
		logic [PAYLOAD_W-1:0] frame_payload;
		phase_t               phase_now;
		logic                 timed_out;
		logic [31:0]          bytes_sent;
	} rsp_item_t;

endpackage

`default_nettype wire

/* sv/cfps_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

// Incoming events: poll, received frame or millisecond tick.
interface cfps_req_if;
	logic                         valid;
	logic                         ready;
	cfps_pkg::req_kind_t          req_type;
	logic [3:0]                   rx_length;
	logic [7:0]                   rx_first_byte;
	logic [cfps_pkg::CHUNK_W-1:0] chunk_bytes;

	modport source (output valid, req_type, rx_length, rx_first_byte, chunk_bytes,
		input ready);
	modport sink (input valid, req_type, rx_length, rx_first_byte, chunk_bytes,
		output ready);
endinterface

// One result per event.
interface cfps_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           frame_valid;
	logic [7:0]                     frame_code;
	logic [3:0]                     frame_length;
	logic [cfps_pkg::PAYLOAD_W-1:0] frame_payload;
	cfps_pkg::phase_t               phase_now;
	logic                           timed_out;
	logic [31:0]                    bytes_sent;

	modport source (output valid, frame_valid, frame_code, frame_length, frame_payload,
		phase_now, timed_out, bytes_sent, input ready);
	modport sink (input valid, frame_valid, frame_code, frame_length, frame_payload,
		phase_now, timed_out, bytes_sent, output ready);
endinterface

// Register write channel.
interface cfps_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [cfps_pkg::CFG_IDX_W-1:0]  index;
	logic [cfps_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/cfps_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfps_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	cfps_cfg_if.sink           cfg,
	output cfps_pkg::cfg_regs_t regs
);

	cfps_pkg::cfg_regs_t regs_q;

	// Writes are always taken.
	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	// Register file; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.image_size <= '0;
			regs_q.ready_timeout_ms <= cfps_pkg::READY_TIMEOUT_RST;
			regs_q.code_request <= '0;
			regs_q.code_ready <= '0;
			regs_q.code_ack <= '0;
			regs_q.code_data <= '0;
			regs_q.code_end <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				cfps_pkg::CFG_IMAGE_SIZE: regs_q.image_size <= cfg.data;
				cfps_pkg::CFG_READY_TIMEOUT: regs_q.ready_timeout_ms <= cfg.data[15:0];
				cfps_pkg::CFG_CODE_REQUEST: regs_q.code_request <= cfg.data[7:0];
				cfps_pkg::CFG_CODE_READY: regs_q.code_ready <= cfg.data[7:0];
				cfps_pkg::CFG_CODE_ACK: regs_q.code_ack <= cfg.data[7:0];
				cfps_pkg::CFG_CODE_DATA: regs_q.code_data <= cfg.data[7:0];
				cfps_pkg::CFG_CODE_END: regs_q.code_end <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/cfps_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfps_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	cfps_req_if.sink            req,
	input  wire logic           take,
	output logic                item_valid,
	output cfps_pkg::req_item_t item
);

	logic                valid_s1;
	cfps_pkg::req_item_t item_s1;

	// Room whenever the stage is empty or drains this cycle.
	assign req.ready = !valid_s1 || take;
	assign item_valid = valid_s1;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Payload capture.
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.req_type <= req.req_type;
			item_s1.rx_length <= req.rx_length;
			item_s1.rx_first_byte <= req.rx_first_byte;
			item_s1.chunk_bytes <= req.chunk_bytes;
		end
	end

endmodule

`default_nettype wire

/* sv/cfps_core.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "can_firmware_push_sequencer_top_macros.svh"

module cfps_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cfps_pkg::cfg_regs_t regs,
	input  wire logic           item_valid,
	input  wire cfps_pkg::req_item_t item,
	output logic                take,
	cfps_rsp_if.source          rsp
);

	localparam int unsigned NW = cfps_pkg::CHUNK_NW;

	cfps_pkg::phase_t phase_q, phase_nxt;
	logic [31:0] offset_q, offset_nxt;
	logic [cfps_pkg::SEQ_W-1:0] seq_q, seq_nxt;
	logic [15:0] wait_q, wait_nxt;

	logic                  out_valid_q;
	cfps_pkg::rsp_item_t   out_q;
	cfps_pkg::rsp_item_t   res;

	logic [31:0]                    remain;
	logic                           has_more;
	logic [NW-1:0]                  chunk_n;
	logic [cfps_pkg::CHUNK_W-1:0]   chunk_masked;
	logic                           is_request;
	logic                           is_ready;

	// An event is processed when the result register is free or being read.
	assign take = item_valid && (!out_valid_q || rsp.ready);

	// Data frame sizing: remaining bytes capped at one chunk.
	always_comb begin
		remain = regs.image_size - offset_q;
		has_more = offset_q < regs.image_size;
		chunk_n = (remain > 32'(cfps_pkg::MAX_CHUNK)) ? NW'(cfps_pkg::MAX_CHUNK)
			: remain[NW-1:0];
		chunk_masked = '0;
		for (int i = 0; i < int'(cfps_pkg::MAX_CHUNK); i++) begin
			if (NW'(i) < chunk_n) begin
				chunk_masked[8*i +: 8] = item.chunk_bytes[8*i +: 8];
			end
		end
		is_request = (item.rx_length != 4'd0) && (item.rx_first_byte == regs.code_request);
		is_ready = (item.rx_length != 4'd0) && (item.rx_first_byte == regs.code_ready);
	end

	// Sequencer next state and result.
	always_comb begin
		phase_nxt = phase_q;
		offset_nxt = offset_q;
		seq_nxt = seq_q;
		wait_nxt = wait_q;
		res = '0;
		case (item.req_type) inside
			cfps_pkg::REQ_TICK: begin
				if (wait_q != 16'hFFFF) begin
					wait_nxt = wait_q + 16'd1;
				end
			end
			cfps_pkg::REQ_POLL, cfps_pkg::REQ_FRAME: begin
				unique case (phase_q)
					cfps_pkg::PH_REQ: begin
						if (item.req_type == cfps_pkg::REQ_FRAME && is_request) begin
							res.frame_valid = 1'b1;
							res.frame_code = regs.code_ack;
							res.frame_length = cfps_pkg::LEN_ACK;
							res.frame_payload = cfps_pkg::PAYLOAD_W'(regs.image_size);
							offset_nxt = '0;
							seq_nxt = '0;
							wait_nxt = '0;
							phase_nxt = cfps_pkg::PH_READY;
						end
					end
					cfps_pkg::PH_READY: begin
						if (wait_q > regs.ready_timeout_ms) begin
							res.timed_out = 1'b1;
							phase_nxt = cfps_pkg::PH_REQ;
						end else if (item.req_type == cfps_pkg::REQ_FRAME && is_ready) begin
							phase_nxt = cfps_pkg::PH_SEND;
						end
					end
					cfps_pkg::PH_SEND: begin
						if (item.req_type == cfps_pkg::REQ_POLL) begin
							res.frame_valid = 1'b1;
							if (has_more) begin
								res.frame_code = regs.code_data;
								res.frame_length = cfps_pkg::LEN_DATA_BASE + 4'(chunk_n);
								res.frame_payload = {chunk_masked, seq_q};
								offset_nxt = offset_q + 32'(chunk_n);
								seq_nxt = seq_q + 16'd1;
							end else begin
								res.frame_code = regs.code_end;
								res.frame_length = cfps_pkg::LEN_END;
								phase_nxt = cfps_pkg::PH_REQ;
							end
						end
					end
					default: begin
						// Bad phase recovers on a poll.
						if (item.req_type == cfps_pkg::REQ_POLL) begin
							phase_nxt = cfps_pkg::PH_REQ;
						end
					end
				endcase
			end
			default: begin
			end
		endcase
		res.phase_now = phase_nxt;
		res.bytes_sent = offset_nxt;
	end

	// Sequencer state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfps_pkg::PH_REQ;
			offset_q <= '0;
			seq_q <= '0;
			wait_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_nxt;
				offset_q <= offset_nxt;
				seq_q <= seq_nxt;
				wait_q <= wait_nxt;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.frame_valid = out_q.frame_valid;
	assign rsp.frame_code = out_q.frame_code;
	assign rsp.frame_length = out_q.frame_length;
	assign rsp.frame_payload = out_q.frame_payload;
	assign rsp.phase_now = out_q.phase_now;
	assign rsp.timed_out = out_q.timed_out;
	assign rsp.bytes_sent = out_q.bytes_sent;

	// A processed event always leaves a result behind.
	`CFPS_ASSERT_NXT(a_take_fills, clk, arst_n, take, out_valid_q)
	// A timeout sends nothing and returns to waiting for a request.
	`CFPS_ASSERT_IMP(a_timeout_idle, clk, arst_n, out_valid_q && out_q.timed_out,
		!out_q.frame_valid && out_q.phase_now == cfps_pkg::PH_REQ)
	// A data frame longer than an ACK leaves the sequencer still sending.
	`CFPS_ASSERT_IMP(a_data_len, clk, arst_n,
		out_valid_q && out_q.frame_valid && out_q.frame_length > cfps_pkg::LEN_ACK,
		out_q.phase_now == cfps_pkg::PH_SEND)
	// A tick never produces a frame.
	`CFPS_ASSERT_NXT(a_tick_silent, clk, arst_n,
		take && item.req_type == cfps_pkg::REQ_TICK, !out_q.frame_valid && !out_q.timed_out)

endmodule

`default_nettype wire

/* sv/can_firmware_push_sequencer_top.sv */
// Firmware push sequencer over CAN, one result for every event.
// An accepted event passes through the input register and then the result
// register, where its result is held until the result side takes it.
// Throughput: one event per cycle while results are taken; the state update is a single compare/add pass.
// Reset (arst_n low, asynchronous): waiting for a request, offset, sequence and
// wait counter cleared, registers at their reset values, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module can_firmware_push_sequencer_top (
	input wire logic  clk,
	input wire logic  arst_n,
	cfps_req_if.sink   req,
	cfps_rsp_if.source rsp,
	cfps_cfg_if.sink   cfg
);

	cfps_pkg::cfg_regs_t regs;
	cfps_pkg::req_item_t item;
	logic                item_valid;
	logic                take;

	cfps_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	cfps_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	cfps_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.regs       (regs),
		.item_valid (item_valid),
		.item       (item),
		.take       (take),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

/* sim/tb_can_firmware_push_sequencer_top.sv */
`timescale 1ns / 1ps

module tb_can_firmware_push_sequencer_top;
	import cfps_pkg::*;

	// Codes that the package leaves unnamed.
	localparam req_kind_t REQ_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

	localparam int STALL_LIMIT = 500;
	localparam int SETTING_COUNT = 8;
	localparam int EVENTS_PER_SETTING = 141;

	// One line of the directed plan: a register write or a request.
	typedef struct packed {
		bit                    is_write;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_data;
		req_item_t             ev;
		bit                    typed;
		rsp_item_t             want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	cfps_req_if req_bus();
	cfps_rsp_if rsp_bus();
	cfps_cfg_if cfg_bus();

	can_firmware_push_sequencer_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	// Shadow of the registers and of the push state.
	cfg_regs_t   shadow_regs;
	phase_t      seq_phase;
	logic [31:0] sent_off;
	logic [15:0] seq_no;
	logic [15:0] ms_waited;

	rsp_item_t frames_due[$];
	rsp_item_t oldest_due;
	plan_row_t directed_rows[$];

	int  mismatches = 0;
	int  events_sent = 0;
	int  frames_sent = 0;
	int  ready_timeouts = 0;
	int  images_done = 0;
	int  stall_cycles = 0;
	bit  no_idle = 1'b0;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Applies one register write to the shadow copy.
	function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		case (idx)
			CFG_IMAGE_SIZE:    shadow_regs.image_size = data;
			CFG_READY_TIMEOUT: shadow_regs.ready_timeout_ms = data[15:0];
			CFG_CODE_REQUEST:  shadow_regs.code_request = data[7:0];
			CFG_CODE_READY:    shadow_regs.code_ready = data[7:0];
			CFG_CODE_ACK:      shadow_regs.code_ack = data[7:0];
			CFG_CODE_DATA:     shadow_regs.code_data = data[7:0];
			CFG_CODE_END:      shadow_regs.code_end = data[7:0];
			default: ;
		endcase
	endfunction

	// Advances the push state by one request and returns the frame it causes.
	function automatic rsp_item_t advance_push(req_item_t ev);
		rsp_item_t   r;
		logic [31:0] remain;
		logic [3:0]  n;
		logic [39:0] kept;
		r = '0;
		if (ev.req_type == REQ_TICK) begin
			if (ms_waited != 16'hFFFF)
				ms_waited = ms_waited + 16'd1;
		end else if (ev.req_type == REQ_POLL || ev.req_type == REQ_FRAME) begin
			case (seq_phase)
				PH_REQ: begin
					if (ev.req_type == REQ_FRAME && ev.rx_length != 4'd0 &&
							ev.rx_first_byte == shadow_regs.code_request) begin
						r.frame_valid = 1'b1;
						r.frame_code = shadow_regs.code_ack;
						r.frame_length = LEN_ACK;
						r.frame_payload = {24'd0, shadow_regs.image_size};
						sent_off = '0;
						seq_no = '0;
						ms_waited = '0;
						seq_phase = PH_READY;
					end
				end
				PH_READY: begin
					if (ms_waited > shadow_regs.ready_timeout_ms) begin
						r.timed_out = 1'b1;
						seq_phase = PH_REQ;
					end else if (ev.req_type == REQ_FRAME && ev.rx_length != 4'd0 &&
							ev.rx_first_byte == shadow_regs.code_ready) begin
						seq_phase = PH_SEND;
					end
				end
				PH_SEND: begin
					if (ev.req_type == REQ_POLL) begin
						r.frame_valid = 1'b1;
						if (sent_off < shadow_regs.image_size) begin
							remain = shadow_regs.image_size - sent_off;
							n = (remain > MAX_CHUNK) ? 4'(MAX_CHUNK) : remain[3:0];
							kept = ev.chunk_bytes & ((40'd1 << (8 * n)) - 40'd1);
							r.frame_code = shadow_regs.code_data;
							r.frame_length = LEN_DATA_BASE + n;
							r.frame_payload = {kept, seq_no};
							sent_off = sent_off + 32'(n);
							seq_no = seq_no + 16'd1;
						end else begin
							r.frame_code = shadow_regs.code_end;
							r.frame_length = LEN_END;
							seq_phase = PH_REQ;
						end
					end
				end
				default: begin
					// The bad phase falls back to waiting on a poll.
					if (ev.req_type == REQ_POLL)
						seq_phase = PH_REQ;
				end
			endcase
		end
		r.phase_now = seq_phase;
		r.bytes_sent = sent_off;
		return r;
	endfunction

	function automatic logic [39:0] rand_chunk();
		return 40'({$urandom, $urandom});
	endfunction

	function automatic req_item_t mk_event(req_kind_t kind, logic [3:0] len,
			logic [7:0] first, logic [39:0] chunk);
		req_item_t e;
		e.req_type = kind;
		e.rx_length = len;
		e.rx_first_byte = first;
		e.chunk_bytes = chunk;
		return e;
	endfunction

	function automatic rsp_item_t frame_of(logic v, logic [7:0] code, logic [3:0] len,
			logic [55:0] payload, phase_t ph, logic tmo, logic [31:0] sent);
		return {v, code, len, payload, ph, tmo, sent};
	endfunction

	function automatic plan_row_t ev_row(req_item_t ev);
		plan_row_t row;
		row = '0;
		row.ev = ev;
		return row;
	endfunction

	function automatic plan_row_t typed_row(req_item_t ev, rsp_item_t want);
		plan_row_t row;
		row = ev_row(ev);
		row.typed = 1'b1;
		row.want = want;
		return row;
	endfunction

	function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		plan_row_t row;
		row = '0;
		row.is_write = 1'b1;
		row.reg_idx = idx;
		row.reg_data = data;
		return row;
	endfunction

	// Fills the bits above a narrow register with random junk.
	function automatic logic [31:0] with_junk(logic [31:0] val, int unsigned w);
		return ($urandom & ~((32'd1 << w) - 32'd1)) | val;
	endfunction

	// Random request steered by the current phase, with some noise mixed in.
	function automatic req_item_t pick_event();
		int         roll;
		logic [7:0] first;
		roll = $urandom_range(0, 99);
		case (seq_phase)
			PH_REQ: begin
				if (roll < 70)
					return mk_event(REQ_FRAME, 4'($urandom_range(1, 15)),
						shadow_regs.code_request, rand_chunk());
			end
			PH_READY: begin
				if (roll < 30)
					return mk_event(REQ_FRAME, 4'($urandom_range(1, 15)),
						shadow_regs.code_ready, rand_chunk());
				else if (roll < 75)
					return mk_event(REQ_TICK, 4'($urandom), 8'($urandom), rand_chunk());
				else if (roll < 85)
					return mk_event(REQ_POLL, 4'($urandom), 8'($urandom), rand_chunk());
			end
			PH_SEND: begin
				if (roll < 75)
					return mk_event(REQ_POLL, 4'($urandom), 8'($urandom), rand_chunk());
			end
			default: ;
		endcase
		case ($urandom_range(0, 2))
			0: first = shadow_regs.code_request;
			1: first = shadow_regs.code_ready;
			default: first = 8'($urandom);
		endcase
		return mk_event(req_kind_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), first,
			rand_chunk());
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Sends one request after a random gap (none in the steady setting) and records its expected frame.
	task automatic drive_event(input req_item_t ev, input bit typed, input rsp_item_t want);
		int        gap;
		phase_t    prior_phase;
		rsp_item_t pred;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		cfg_bus.valid <= 1'b0;
		if (gap != 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.req_type <= ev.req_type;
		req_bus.rx_length <= ev.rx_length;
		req_bus.rx_first_byte <= ev.rx_first_byte;
		req_bus.chunk_bytes <= ev.chunk_bytes;
		req_bus.valid <= 1'b1;
		do @(posedge clk); while (!req_bus.ready);
		prior_phase = seq_phase;
		pred = advance_push(ev);
		frames_due.push_back(typed ? want : pred);
		events_sent++;
		frames_sent += int'(pred.frame_valid);
		ready_timeouts += int'(pred.timed_out);
		if (prior_phase == PH_SEND && pred.phase_now == PH_REQ)
			images_done++;
	endtask

	// Holds off new requests until every expected frame has come back.
	task automatic drain_results();
		req_bus.valid <= 1'b0;
		cfg_bus.valid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_bus.index <= idx;
		cfg_bus.data <= data;
		cfg_bus.valid <= 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		shadow_write(idx, data);
	endtask

	// Programs one register setting; some settings sit at the extremes.
	task automatic set_phase(input int p);
		logic [31:0] img;
		logic [15:0] tmo;
		logic [7:0]  c_req, c_rdy, c_ack, c_dat, c_end;
		c_req = 8'($urandom);
		c_rdy = 8'($urandom);
		c_ack = 8'($urandom);
		c_dat = 8'($urandom);
		c_end = 8'($urandom);
		case (p)
			0: begin
				img = $urandom_range(1, 40);
				tmo = 16'($urandom_range(1, 12));
			end
			1: begin
				img = '0;
				tmo = '0;
				c_rdy = c_req;
			end
			2: begin
				img = 32'hFFFF_FFFF;
				tmo = 16'hFFFF;
				{c_req, c_rdy, c_ack, c_dat, c_end} = '1;
			end
			3: begin
				// Smaller than the offset left by the previous setting.
				img = $urandom_range(1, 12);
				tmo = READY_TIMEOUT_RST;
				{c_req, c_rdy, c_ack, c_dat, c_end} = '0;
			end
			default: begin
				img = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) :
					$urandom_range(6, 60);
				case ($urandom_range(0, 2))
					0: tmo = '0;
					1: tmo = 16'($urandom_range(1, 8));
					default: tmo = 16'hFFFF;
				endcase
			end
		endcase
		no_idle <= (p == 3);
		drain_results();
		write_reg(CFG_IMAGE_SIZE, img);
		write_reg(CFG_READY_TIMEOUT, with_junk(32'(tmo), 16));
		write_reg(CFG_CODE_REQUEST, with_junk(32'(c_req), 8));
		write_reg(CFG_CODE_READY, with_junk(32'(c_rdy), 8));
		write_reg(CFG_CODE_ACK, with_junk(32'(c_ack), 8));
		write_reg(CFG_CODE_DATA, with_junk(32'(c_dat), 8));
		write_reg(CFG_CODE_END, with_junk(32'(c_end), 8));
	endtask

	// Result side: random stall before each frame, none in the steady setting.
	initial begin
		int stall;
		rsp_bus.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
		end
	end

	// Compares each returned frame with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (frames_due.size() == 0) begin
				$error("frame returned with no request outstanding");
				mismatches++;
			end else begin
				oldest_due = frames_due.pop_front();
				check_field("frame_valid", 64'(oldest_due.frame_valid),
					64'(rsp_bus.frame_valid));
				check_field("frame_code", 64'(oldest_due.frame_code),
					64'(rsp_bus.frame_code));
				check_field("frame_length", 64'(oldest_due.frame_length),
					64'(rsp_bus.frame_length));
				check_field("frame_payload", 64'(oldest_due.frame_payload),
					64'(rsp_bus.frame_payload));
				check_field("phase_now", 64'(oldest_due.phase_now),
					64'(rsp_bus.phase_now));
				check_field("timed_out", 64'(oldest_due.timed_out),
					64'(rsp_bus.timed_out));
				check_field("bytes_sent", 64'(oldest_due.bytes_sent),
					64'(rsp_bus.bytes_sent));
			end
		end
	end

	// Ends the run if no channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Stimulus: directed plan, then random traffic over several settings.
	initial begin
		int        counted;
		plan_row_t row;

		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.req_type <= REQ_POLL;
		req_bus.rx_length <= '0;
		req_bus.rx_first_byte <= '0;
		req_bus.chunk_bytes <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= '0;
		cfg_bus.data <= '0;

		shadow_regs = '0;
		shadow_regs.ready_timeout_ms = READY_TIMEOUT_RST;
		seq_phase = PH_REQ;
		sent_off = '0;
		seq_no = '0;
		ms_waited = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: every code is zero and the image is empty.
		directed_rows.push_back(typed_row(mk_event(REQ_POLL, 4'd0, 8'h00, '0),
			frame_of(1'b0, 8'h00, 4'd0, '0, PH_REQ, 1'b0, '0)));
		directed_rows.push_back(typed_row(mk_event(REQ_FRAME, 4'd0, 8'h00, '0),
			frame_of(1'b0, 8'h00, 4'd0, '0, PH_REQ, 1'b0, '0)));
		directed_rows.push_back(typed_row(mk_event(REQ_TICK, 4'd0, 8'h00, '0),
			frame_of(1'b0, 8'h00, 4'd0, '0, PH_REQ, 1'b0, '0)));
		directed_rows.push_back(typed_row(mk_event(REQ_UNUSED, 4'hF, 8'hFF, '1),
			frame_of(1'b0, 8'h00, 4'd0, '0, PH_REQ, 1'b0, '0)));
		directed_rows.push_back(typed_row(mk_event(REQ_FRAME, 4'd8, 8'hFF, '1),
			frame_of(1'b0, 8'h00, 4'd0, '0, PH_REQ, 1'b0, '0)));
		directed_rows.push_back(typed_row(mk_event(REQ_FRAME, 4'd1, 8'h00, '0),
			frame_of(1'b1, 8'h00, LEN_ACK, '0, PH_READY, 1'b0, '0)));
		directed_rows.push_back(typed_row(mk_event(REQ_POLL, 4'd0, 8'h00, '0),
			frame_of(1'b0, 8'h00, 4'd0, '0, PH_READY, 1'b0, '0)));
		directed_rows.push_back(typed_row(mk_event(REQ_FRAME, 4'hF, 8'h00, '0),
			frame_of(1'b0, 8'h00, 4'd0, '0, PH_SEND, 1'b0, '0)));
		directed_rows.push_back(typed_row(mk_event(REQ_TICK, 4'd0, 8'h00, '0),
			frame_of(1'b0, 8'h00, 4'd0, '0, PH_SEND, 1'b0, '0)));
		directed_rows.push_back(typed_row(mk_event(REQ_FRAME, 4'd3, 8'h00, '0),
			frame_of(1'b0, 8'h00, 4'd0, '0, PH_SEND, 1'b0, '0)));
		// Empty image: the first poll while sending ends the transfer.
		directed_rows.push_back(typed_row(mk_event(REQ_POLL, 4'd0, 8'h00, '1),
			frame_of(1'b1, 8'h00, LEN_END, '0, PH_REQ, 1'b0, '0)));
		// Distinct codes and a zero ready timeout.
		directed_rows.push_back(reg_row(CFG_IMAGE_SIZE, 32'd7));
		directed_rows.push_back(reg_row(CFG_READY_TIMEOUT, 32'hFFFF_0000));
		directed_rows.push_back(reg_row(CFG_CODE_REQUEST, 32'h0000_005A));
		directed_rows.push_back(reg_row(CFG_CODE_READY, 32'hFFFF_FFA5));
		directed_rows.push_back(reg_row(CFG_CODE_ACK, 32'h0000_0011));
		directed_rows.push_back(reg_row(CFG_CODE_DATA, 32'h0000_0022));
		directed_rows.push_back(reg_row(CFG_CODE_END, 32'h0000_0033));
		directed_rows.push_back(reg_row(CFG_UNUSED_IDX, 32'hFFFF_FFFF));
		directed_rows.push_back(typed_row(mk_event(REQ_FRAME, 4'd2, 8'h5A, '0),
			frame_of(1'b1, 8'h11, LEN_ACK, 56'd7, PH_READY, 1'b0, '0)));
		// One tick passes the zero timeout, so the ready frame is dropped.
		directed_rows.push_back(typed_row(mk_event(REQ_TICK, 4'd0, 8'h00, '0),
			frame_of(1'b0, 8'h00, 4'd0, '0, PH_READY, 1'b0, '0)));
		directed_rows.push_back(typed_row(mk_event(REQ_FRAME, 4'd1, 8'hA5, '0),
			frame_of(1'b0, 8'h00, 4'd0, '0, PH_REQ, 1'b1, '0)));
		directed_rows.push_back(ev_row(mk_event(REQ_FRAME, 4'd8, 8'h5A, '0)));
		directed_rows.push_back(ev_row(mk_event(REQ_FRAME, 4'd1, 8'hA5, '0)));
		directed_rows.push_back(ev_row(mk_event(REQ_POLL, 4'd0, 8'h00, '1)));
		// Image shrunk below the offset mid-transfer: the next poll ends it.
		directed_rows.push_back(reg_row(CFG_IMAGE_SIZE, 32'd3));
		directed_rows.push_back(typed_row(mk_event(REQ_POLL, 4'd0, 8'h00, 40'hA5A5A5A5A5),
			frame_of(1'b1, 8'h33, LEN_END, '0, PH_REQ, 1'b0, 32'd5)));

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_write) begin
				drain_results();
				write_reg(row.reg_idx, row.reg_data);
			end else begin
				drive_event(row.ev, row.typed, row.want);
			end
		end

		for (int p = 0; p < SETTING_COUNT; p++) begin
			set_phase(p);
			counted = 0;
			while (counted < EVENTS_PER_SETTING) begin
				if ($urandom_range(0, 59) == 0)
					drain_results();
				drive_event(pick_event(), 1'b0, '0);
				counted++;
			end
		end

		drain_results();
		repeat (8) @(posedge clk);

		$display("Run covered %0d requests over %0d register settings after the directed plan.",
			events_sent, SETTING_COUNT);
		$display("Frames sent %0d, ready timeouts %0d, images finished %0d, mismatches %0d.",
			frames_sent, ready_timeouts, images_done, mismatches);
		if (mismatches == 0 && frames_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+sv
sv/cfps_pkg.sv
sv/cfps_ifs.sv
sv/cfps_cfg.sv
sv/cfps_in_stage.sv
sv/cfps_core.sv
sv/can_firmware_push_sequencer_top.sv
sim/tb_can_firmware_push_sequencer_top.sv
